// ----- sv/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types, constants and the exponent table of the gradient unit.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int MAX_CLASSES    = 64;
    localparam int IDX_W          = $clog2(MAX_CLASSES);
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;

    localparam logic [1:0] CFG_CLASS_COUNT   = 2'd0;
    localparam logic [1:0] CFG_BATCH_COUNT   = 2'd1;
    localparam logic [1:0] CFG_UPSTREAM_GRAD = 2'd2;

    typedef struct packed {
        logic [6:0]  class_count;
        logic [15:0] batch_count;
        logic [15:0] upstream_grad;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      logit;
        logic [5:0]       target;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } item_t;

    typedef logic [15:0] exp_tab_t [EXP_TABLE_SIZE];

    function automatic exp_tab_t build_exp_table();
        exp_tab_t    tab;
        logic [63:0] y;
        logic [63:0] p2;
        logic [63:0] p3;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] a;
        for (int k = 0; k < EXP_TABLE_SIZE; k++)
        begin
            if (k == 0)
            begin
                tab[k] = 16'hFFFF;
            end
            else
            begin
                y  = 64'(k) << (28 - EXP_TABLE_BITS);
                p2 = (y * y) >> 32;
                p3 = (p2 * y) >> 32;
                p4 = (p3 * y) >> 32;
                p5 = (p4 * y) >> 32;
                a  = ((64'd1 << 32) + p2 / 2 + p4 / 24) - (y + p3 / 6 + p5 / 120);
                for (int i = 0; i < 8; i++)
                begin
                    a = (a * a + (64'd1 << 31)) >> 32;
                end
                a = (a + 64'd32768) >> 16;
                tab[k] = (a > 64'd65535) ? 16'hFFFF : a[15:0];
            end
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ----- sv/sce_front.sv -----
// ----------------------------------------------------------------------------
// sce_front
// Takes input beats, tracks the position in the row and tags each item.
// ----------------------------------------------------------------------------
module sce_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [6:0]    class_count,
    input  logic          in_valid,
    input  logic [15:0]   in_logit,
    input  logic [5:0]    in_target,
    input  logic          queue_full,
    output logic          in_ready,
    output logic          push,
    output sce_pkg::item_t push_item
);
    import sce_pkg::*;

    logic [IDX_W-1:0] item_index_reg;
    logic [IDX_W-1:0] item_index_next;
    logic [6:0]       n_active;
    logic             is_last;

    always_comb
    begin
        if (class_count < 7'd2)
            n_active = 7'd2;
        else if (class_count > 7'(MAX_CLASSES))
            n_active = 7'(MAX_CLASSES);
        else
            n_active = class_count;
    end

    assign is_last  = (7'(item_index_reg) + 7'd1) >= n_active;
    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign push_item.logit  = in_logit;
    assign push_item.target = in_target;
    assign push_item.first  = (item_index_reg == '0);
    assign push_item.last   = is_last;
    assign push_item.idx    = item_index_reg;

    assign item_index_next = is_last ? '0 : item_index_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_index_reg <= '0;
        else if (push)
            item_index_reg <= item_index_next;
    end

endmodule

// ----- sv/sce_queue.sv -----
// ----------------------------------------------------------------------------
// sce_queue
// Four-entry queue between the front and the back of the unit.
// ----------------------------------------------------------------------------
module sce_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sce_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output sce_pkg::item_t head
);
    import sce_pkg::*;

    item_t      entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign full  = (count_reg == 3'd4);
    assign empty = (count_reg == 3'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 3'd1;
        else if (pop && !push)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/sce_div.sv -----
// ----------------------------------------------------------------------------
// sce_div
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module sce_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [22:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);
    logic [22:0] rem_reg;
    logic [32:0] quo_reg;
    logic [22:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [23:0] shifted;
    logic        ge;
    logic [23:0] diff;

    assign shifted  = {rem_reg, quo_reg[32]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[22:0] : shifted[22:0];
            quo_reg <= {quo_reg[31:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- sv/sce_back.sv -----
// ----------------------------------------------------------------------------
// sce_back
// Stores a row, sums the exponents and emits the saturated gradients.
// ----------------------------------------------------------------------------
module sce_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    batch_count,
    input  logic [15:0]    upstream_grad,
    input  logic           q_empty,
    input  sce_pkg::item_t q_head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_gradient,
    output logic           out_last
);
    import sce_pkg::*;

    typedef enum logic [11:0] {
        ST_LOAD  = 12'b000000000001,
        ST_S_RD  = 12'b000000000010,
        ST_S_EXP = 12'b000000000100,
        ST_S_ACC = 12'b000000001000,
        ST_E_RD  = 12'b000000010000,
        ST_E_EXP = 12'b000000100000,
        ST_E_DV1 = 12'b000001000000,
        ST_E_WT1 = 12'b000010000000,
        ST_E_MUL = 12'b000100000000,
        ST_E_DV2 = 12'b001000000000,
        ST_E_WT2 = 12'b010000000000,
        ST_E_OUT = 12'b100000000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [15:0]       mem [MAX_CLASSES];
    logic [15:0]       mem_rd_reg;
    logic [15:0]       row_max_reg;
    logic [5:0]        row_target_reg;
    logic [22:0]       exp_sum_reg;
    logic [15:0]       exp_reg;
    logic [15:0]       sm_reg;
    logic signed [33:0] prod_reg;
    logic [IDX_W-1:0]  cls_reg;
    logic [IDX_W-1:0]  last_idx_reg;
    logic              out_valid_reg;
    logic [31:0]       grad_reg;
    logic              last_reg;

    logic [16:0]       gap;
    logic [11+EXP_TABLE_BITS:0] kshift;
    logic [EXP_TABLE_BITS-1:0]  k;
    logic [15:0]       exp_val;
    logic              div_start;
    logic [32:0]       div_dividend;
    logic [22:0]       div_divisor;
    logic              div_done;
    logic [32:0]       div_q;
    logic [15:0]       bc_eff;
    logic [15:0]       sm_val;
    logic signed [17:0] diff;
    logic              prod_neg;
    logic [33:0]       prod_mag;
    logic [31:0]       grad_sat;
    logic              cls_last;

    assign pop          = (state_reg == ST_LOAD) && !q_empty;
    assign out_valid    = out_valid_reg;
    assign out_gradient = grad_reg;
    assign out_last     = last_reg;
    assign cls_last     = (cls_reg == last_idx_reg);

    assign gap     = {row_max_reg[15], row_max_reg} - {mem_rd_reg[15], mem_rd_reg};
    assign kshift  = {gap[11:0], {EXP_TABLE_BITS{1'b0}}};
    assign k       = kshift[11+EXP_TABLE_BITS:12];
    assign exp_val = (|gap[15:12]) ? 16'd0 : EXP_TABLE[k];

    assign bc_eff   = (batch_count == 16'd0) ? 16'd1 : batch_count;
    assign sm_val   = (exp_sum_reg == 23'd0) ? 16'd0
                    : ((|div_q[32:16]) ? 16'hFFFF : div_q[15:0]);
    assign diff     = $signed({2'b00, sm_reg})
                    - ((cls_reg == row_target_reg) ? 18'sd65536 : 18'sd0);
    assign prod_neg = prod_reg < 0;
    assign prod_mag = prod_neg ? 34'(-prod_reg) : 34'(prod_reg);

    always_comb
    begin
        if (prod_neg)
            grad_sat = (div_q > 33'h080000000) ? 32'h80000000 : 32'(-div_q);
        else
            grad_sat = (div_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {1'b0, exp_reg, 16'd0} + 33'(exp_sum_reg >> 1);
        div_divisor  = exp_sum_reg;
        if (state_reg == ST_E_DV1)
            div_start = 1'b1;
        if (state_reg == ST_E_DV2)
        begin
            div_start    = 1'b1;
            div_dividend = 33'(prod_mag) + 33'(bc_eff);
            div_divisor  = 23'({bc_eff, 1'b0});
        end
    end

    sce_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (pop && q_head.last)
                    state_next = ST_S_RD;
            end
            ST_S_RD:  state_next = ST_S_EXP;
            ST_S_EXP: state_next = ST_S_ACC;
            ST_S_ACC: state_next = cls_last ? ST_E_RD : ST_S_RD;
            ST_E_RD:  state_next = ST_E_EXP;
            ST_E_EXP: state_next = ST_E_DV1;
            ST_E_DV1: state_next = ST_E_WT1;
            ST_E_WT1:
            begin
                if (div_done)
                    state_next = ST_E_MUL;
            end
            ST_E_MUL: state_next = ST_E_DV2;
            ST_E_DV2: state_next = ST_E_WT2;
            ST_E_WT2:
            begin
                if (div_done)
                    state_next = ST_E_OUT;
            end
            ST_E_OUT:
            begin
                if (out_ready)
                    state_next = cls_last ? ST_LOAD : ST_E_RD;
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            mem[q_head.idx] <= q_head.logit;
        mem_rd_reg <= mem[cls_reg];
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_val;
        if (state_reg == ST_E_WT1 && div_done)
            sm_reg <= sm_val;
        if (state_reg == ST_E_MUL)
            prod_reg <= diff * $signed(upstream_grad);
        if (state_reg == ST_E_WT2 && div_done)
        begin
            grad_reg <= grad_sat;
            last_reg <= cls_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            row_max_reg    <= '0;
            row_target_reg <= '0;
            exp_sum_reg    <= '0;
            cls_reg        <= '0;
            last_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                if (q_head.first)
                begin
                    row_max_reg    <= q_head.logit;
                    row_target_reg <= q_head.target;
                end
                else if ($signed(q_head.logit) > $signed(row_max_reg))
                begin
                    row_max_reg <= q_head.logit;
                end
                if (q_head.last)
                begin
                    last_idx_reg <= q_head.idx;
                    cls_reg      <= '0;
                    exp_sum_reg  <= '0;
                end
            end
            if (state_reg == ST_S_ACC)
            begin
                exp_sum_reg <= exp_sum_reg + 23'(exp_reg);
                cls_reg     <= cls_last ? '0 : cls_reg + 1'b1;
            end
            if (state_reg == ST_E_WT2 && div_done)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_E_OUT && out_ready)
            begin
                out_valid_reg <= 1'b0;
                cls_reg       <= cls_reg + 1'b1;
            end
        end
    end

endmodule

// ----- sv/softmax_cross_entropy_gradient_unit.sv -----
// ----------------------------------------------------------------------------
// softmax_cross_entropy_gradient_unit
// Softmax cross-entropy gradient over rows of Q8.8 logits.
// ----------------------------------------------------------------------------
// One beat carries one logit; the target class is taken from the first beat
// of a row. Beats are taken one per cycle, while the queue is not full, into
// a four-entry queue and are loaded into the row store at one per cycle
// while the back end is not busy with a row. After the last beat of a row
// the back end reads, exponentiates and accumulates each class in turn to
// sum the exponents, then emits each gradient after two passes through the
// shared 33-step divider, holding it while m_tready is held low;
// last_of_row travels on m_tlast.
module softmax_cross_entropy_gradient_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // logit[15:0], target[21:16], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // gradient[31:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sce_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t q_head;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.class_count   <= 7'd64;
            cfg_reg.batch_count   <= 16'd1;
            cfg_reg.upstream_grad <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CLASS_COUNT:   cfg_reg.class_count   <= cfg_data[6:0];
                CFG_BATCH_COUNT:   cfg_reg.batch_count   <= cfg_data;
                CFG_UPSTREAM_GRAD: cfg_reg.upstream_grad <= cfg_data;
                default:           ;
            endcase
        end
    end

    sce_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .class_count (cfg_reg.class_count),
        .in_valid    (s_tvalid),
        .in_logit    (s_tdata[15:0]),
        .in_target   (s_tdata[21:16]),
        .queue_full  (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_item   (push_item)
    );

    sce_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    sce_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .batch_count   (cfg_reg.batch_count),
        .upstream_grad (cfg_reg.upstream_grad),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_gradient  (m_tdata),
        .out_last      (m_tlast)
    );

endmodule
